// File: design/lnc_pkg.sv
// ----------------------------------------------------------------------------
// lnc_pkg: shared types and constants of the noise channel
// Item structs, configuration register map and the timer base divisor table.
// ----------------------------------------------------------------------------
package lnc_pkg;

    localparam int unsigned SR_W    = 15;
    localparam int unsigned TIMER_W = 22;
    localparam int unsigned VOL_W   = 4;
    localparam int unsigned LVAL_W  = 6;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 8;

    localparam logic [SR_W-1:0]  SR_SEED = 15'h7FFF;
    localparam logic [VOL_W-1:0] VOL_MAX = 4'hF;
    localparam logic [VOL_W-1:0] VOL_MIN = 4'h0;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_DIV_SEL         = 3'd0,
        CFG_FREQ_SHIFT      = 3'd1,
        CFG_NARROW_MODE     = 3'd2,
        CFG_START_VOL       = 3'd3,
        CFG_ENVELOPE_UP     = 3'd4,
        CFG_ENVELOPE_PERIOD = 3'd5,
        CFG_LENGTH_ENABLE   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]       div_sel;
        logic [3:0]       freq_shift;
        logic             narrow_mode;
        logic [VOL_W-1:0] start_vol;
        logic             envelope_up;
        logic [2:0]       envelope_period;
        logic             length_enable;
    } cfg_t;

    typedef struct packed {
        logic              trigger;
        logic              load_length;
        logic [LVAL_W-1:0] length_value;
        logic              length_strobe;
        logic              envelope_strobe;
    } in_item_t;

    typedef struct packed {
        logic [VOL_W-1:0] level;
        logic             active;
    } out_item_t;

    // Base timer divisor for each select code
    localparam logic [6:0] BASE_DIVISOR [8] = '{
        7'd8, 7'd16, 7'd32, 7'd48, 7'd64, 7'd80, 7'd96, 7'd112
    };

endpackage

// File: design/lnc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lnc_cfg_regs: configuration register file
// Decodes indexed writes into the channel's control fields.
// ----------------------------------------------------------------------------
module lnc_cfg_regs
    import lnc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [CIDX_W-1:0]  wr_index,
    input  logic [CDATA_W-1:0] wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed field; ignore unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_DIV_SEL:         cfg_next.div_sel         = wr_data[2:0];
                CFG_FREQ_SHIFT:      cfg_next.freq_shift      = wr_data[3:0];
                CFG_NARROW_MODE:     cfg_next.narrow_mode     = wr_data[0];
                CFG_START_VOL:       cfg_next.start_vol       = wr_data[VOL_W-1:0];
                CFG_ENVELOPE_UP:     cfg_next.envelope_up     = wr_data[0];
                CFG_ENVELOPE_PERIOD: cfg_next.envelope_period = wr_data[2:0];
                CFG_LENGTH_ENABLE:   cfg_next.length_enable   = wr_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/lnc_datapath.sv
// ----------------------------------------------------------------------------
// lnc_datapath: per-tick channel state update
// Length counter, trigger, envelope, period timer and LFSR step for one item.
// ----------------------------------------------------------------------------
module lnc_datapath
    import lnc_pkg::*;
#(
    parameter int unsigned LENGTH_RELOAD = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam int unsigned LEN_W =
        ($clog2(LENGTH_RELOAD + 1) > LVAL_W) ? $clog2(LENGTH_RELOAD + 1) : LVAL_W;
    localparam logic [LEN_W-1:0] LEN_RELOAD = LEN_W'(LENGTH_RELOAD);

    logic [SR_W-1:0]    sr_reg,    sr_next;
    logic               on_reg,    on_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [LEN_W-1:0]   len_reg,   len_next;
    logic [VOL_W-1:0]   vol_reg,   vol_next;
    logic               noise_reg, noise_next;

    logic [LEN_W-1:0]   len_load;
    logic [TIMER_W-1:0] period;
    logic               fb;
    logic [SR_W-1:0]    sr_start;
    logic [SR_W-1:0]    sr_stepped;

    // Timer period: base divisor shifted left
    assign period = {{(TIMER_W-7){1'b0}}, BASE_DIVISOR[cfg.div_sel]} << cfg.freq_shift;

    always_comb
    begin
        // Length load and trigger
        len_load = item.load_length ? LEN_W'(item.length_value) : len_reg;
        on_next  = on_reg | item.trigger;
        len_next = (item.trigger && len_load == '0) ? LEN_RELOAD : len_load;
        sr_start = item.trigger ? SR_SEED : sr_reg;
        vol_next = item.trigger ? cfg.start_vol : vol_reg;

        // Length strobe: count down and silence at zero
        if (item.length_strobe && cfg.length_enable && len_next != '0)
        begin
            len_next = len_next - LEN_W'(1);
            if (len_next == '0)
            begin
                on_next = 1'b0;
            end
        end

        // Envelope strobe: saturating step
        if (item.envelope_strobe && cfg.envelope_period != 3'd0)
        begin
            if (cfg.envelope_up)
            begin
                if (vol_next != VOL_MAX)
                begin
                    vol_next = vol_next + VOL_W'(1);
                end
            end
            else if (vol_next != VOL_MIN)
            begin
                vol_next = vol_next - VOL_W'(1);
            end
        end

        // LFSR step candidate
        fb         = sr_start[0] ^ sr_start[1];
        sr_stepped = {fb, sr_start[SR_W-1:1]};
        if (cfg.narrow_mode)
        begin
            sr_stepped[6] = fb;
        end

        // Timer: reload and step on zero, else count down
        sr_next    = sr_start;
        timer_next = timer_reg;
        noise_next = noise_reg;
        if (on_next)
        begin
            if (timer_reg == '0)
            begin
                timer_next = period;
                sr_next    = sr_stepped;
                noise_next = ~sr_stepped[0];
            end
            else
            begin
                timer_next = timer_reg - TIMER_W'(1);
            end
        end

        // Result for this tick
        result.active = on_next;
        result.level  = (on_next && noise_next) ? vol_next : VOL_MIN;
    end

    // Advance state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg    <= '0;
            on_reg    <= 1'b0;
            timer_reg <= '0;
            len_reg   <= '0;
            vol_reg   <= '0;
            noise_reg <= 1'b0;
        end
        else if (step)
        begin
            sr_reg    <= sr_next;
            on_reg    <= on_next;
            timer_reg <= timer_next;
            len_reg   <= len_next;
            vol_reg   <= vol_next;
            noise_reg <= noise_next;
        end
    end

    // Timer only moves while the channel runs
    a_timer_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
        step && !on_next |=> timer_reg == $past(timer_reg))
        else $error("period timer moved while channel off");

    // State holds between items
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(sr_reg) && $stable(len_reg) && $stable(vol_reg))
        else $error("channel state changed without an item");

endmodule

// File: design/lnc_out_buf.sv
// ----------------------------------------------------------------------------
// lnc_out_buf: result register with skid stage
// Holds results while the consumer stalls; input side stays open for one more.
// ----------------------------------------------------------------------------
module lnc_out_buf
    import lnc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      can_push,
    output logic      valid,
    input  logic      ready,
    output out_item_t item
);

    logic      main_v_reg, main_v_next;
    logic      skid_v_reg, skid_v_next;
    out_item_t main_reg,   main_next;
    out_item_t skid_reg,   skid_next;
    logic      pop;

    assign pop      = main_v_reg && ready;
    assign can_push = !skid_v_reg;

    // Refill the result register from skid first, then from the new item
    always_comb
    begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (!main_v_reg || pop)
        begin
            if (skid_v_reg)
            begin
                main_next   = skid_reg;
                main_v_next = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                main_next   = push_item;
                main_v_next = push;
            end
        end
        else if (push)
        begin
            skid_next   = push_item;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign valid = main_v_reg;
    assign item  = main_reg;

    // Skid only fills behind a held result
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg)
        else $error("skid entry without result entry");

    // A push into a stalled full result register lands in skid
    a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
        push && main_v_reg && !ready |=> skid_v_reg && skid_reg == $past(push_item))
        else $error("stalled item not captured in skid");

endmodule

// File: design/lfsr_noise_channel_core.sv
// ----------------------------------------------------------------------------
// lfsr_noise_channel_core: LFSR noise channel
// Top level: config registers, per-tick datapath and result buffer.
// ----------------------------------------------------------------------------
// Each input item is one tick. The block accepts one item per clock while
// in_ready is high and returns exactly one result per item: the channel
// state is updated by combinational logic straight into a result register, and
// a skid entry behind that register keeps the input open for one more item
// while the consumer stalls, so sustained throughput is one item per cycle
// whenever out_ready is high. Configuration writes are taken every cycle and
// must only be issued while the channel has no results outstanding.
module lfsr_noise_channel_core
    import lnc_pkg::*;
#(
    parameter int unsigned LENGTH_RELOAD = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    out_item_t result;
    logic      accept;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    lnc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lnc_datapath #(
        .LENGTH_RELOAD (LENGTH_RELOAD)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .item   (in_item),
        .cfg    (cfg),
        .result (result)
    );

    lnc_out_buf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (result),
        .can_push  (in_ready),
        .valid     (out_valid),
        .ready     (out_ready),
        .item      (out_item)
    );

endmodule
